@@ hw/rtl/sld_pkg.sv @@
package sld_pkg;

    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int ESC_DEPTH   = 5;

    localparam logic [7:0] BYTE_DQUOTE    = 8'h22;
    localparam logic [7:0] BYTE_SQUOTE    = 8'h27;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [7:0] BYTE_LOWER_U   = 8'h75;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] UTF8_MIN_LEAD  = 8'hC2;
    localparam logic [7:0] UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0] UTF8_CONT_LO   = 8'h80;
    localparam logic [7:0] UTF8_CONT_HI   = 8'hBF;
    localparam logic [7:0] UTF8_E0_MIN    = 8'hA0;

    localparam logic [1:0] MODE_ASCII  = 2'd0;
    localparam logic [1:0] MODE_UTF8   = 2'd1;
    localparam logic [1:0] MODE_LATIN1 = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NON_ASCII = 2'd1;
    localparam logic [1:0] ERR_BAD_UTF8  = 2'd2;

    localparam logic [1:0] UTF8_NONE  = 2'd0;
    localparam logic [1:0] UTF8_LAST  = 2'd1;
    localparam logic [1:0] UTF8_TWO   = 2'd2;

    localparam logic [2:0] ESC_NONE  = 3'd0;
    localparam logic [2:0] ESC_SLASH = 3'd1;
    localparam logic [2:0] ESC_FULL  = 3'd5;

    typedef enum logic [2:0] {
        KIND_CHAR,
        KIND_CLOSED,
        KIND_UNTERM,
        KIND_NON_ASCII,
        KIND_BAD_UTF8
    } item_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       quote_kind;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_point;
        item_kind_t  item_kind;
        logic        wide_flag;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] result_run_t;

    typedef struct packed {
        logic                      active;
        logic                      qsel;
        logic                      qpend;
        logic [2:0]                esc_stage;
        logic [ESC_DEPTH-1:0][7:0] esc_bytes;
        logic [7:0]                lead;
        logic [7:0]                partial;
        logic [1:0]                remaining;
        logic [1:0]                err;
        logic                      wide;
    } lit_state_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = b - 8'h30;
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = b - 8'h57;
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic result_t char_item(input logic [15:0] cp);
        result_t r;
        r.code_point = cp;
        r.item_kind  = KIND_CHAR;
        r.wide_flag  = 1'b0;
        return r;
    endfunction

endpackage

@@ hw/rtl/string_literal_decoder.sv @@
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_data (encoding mode)
// in        in         in_valid/in_stall    data_byte, first_byte, quote_kind
// out       out        out_valid/out_stall  code_point, item_kind, wide_flag, last_of_run
//
// A source byte is taken every cycle while each byte yields at most one result and the output does not stall.
// A byte that yields k results (escape flush plus one more, up to six) stalls
// the next byte while the result buffer drains them one per cycle, unless the output stalls.
// An input transaction passes the input register and then the result buffer before its first result.
// Reset clears literal state and sets the encoding mode to UTF-8.
// in_stall rises only while the input register waits on a result buffer that is still draining.
module string_literal_decoder
    import sld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        quote_kind,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_point,
    output logic [2:0]  item_kind,
    output logic        wide_flag,
    output logic        last_of_run
);

    in_item_t         in_item;
    in_item_t         item;
    logic             fire;
    logic             run_free;
    result_run_t      run;
    logic [CNT_W-1:0] run_count;
    result_t          result;

    assign cfg_ready          = 1'b1;
    assign in_item.data_byte  = data_byte;
    assign in_item.first_byte = first_byte;
    assign in_item.quote_kind = quote_kind;

    sld_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .run_free (run_free),
        .fire     (fire),
        .item     (item)
    );

    sld_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .run       (run),
        .run_count (run_count)
    );

    sld_run_buf u_run_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .run       (run),
        .run_count (run_count),
        .run_free  (run_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .last      (last_of_run)
    );

    assign code_point = result.code_point;
    assign item_kind  = result.item_kind;
    assign wide_flag  = result.wide_flag;

`ifndef ASSERT_OFF
    // input holds only while the buffer still has results beyond this cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && (out_stall || !last_of_run))
        else $error("input stalled while result buffer drains");

    // a status transaction always closes the run of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != KIND_CHAR |-> last_of_run && code_point == 16'h0000)
        else $error("status transaction not last or carries a code point");

    // character transactions never carry the wide flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_CHAR |-> !wide_flag)
        else $error("wide flag on a character transaction");
`endif

endmodule

@@ hw/rtl/sld_in_stage.sv @@
module sld_in_stage
    import sld_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     run_free,
    output logic     fire,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign fire     = valid_reg && run_free;
    assign in_stall = valid_reg && !run_free;
    assign accept   = in_valid && !in_stall;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ hw/rtl/sld_decode.sv @@
module sld_decode
    import sld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_data,
    input  logic              fire,
    input  in_item_t          item,
    output result_run_t       run,
    output logic [CNT_W-1:0]  run_count
);

    lit_state_t state_reg;
    lit_state_t state_next;
    logic [1:0] mode_reg;

    always_comb
    begin : decode_comb
        lit_state_t  ns;
        result_run_t res;
        logic [CNT_W-1:0] n;
        logic [7:0]  b;
        logic [7:0]  q;
        logic        handled;
        logic        ok;
        logic        cont;
        logic        do_finish;
        item_kind_t  base_kind;
        item_kind_t  fin_kind;
        logic [15:0] cp;

        ns        = state_reg;
        res       = '0;
        n         = '0;
        b         = item.data_byte;
        handled   = 1'b0;
        do_finish = 1'b0;
        base_kind = KIND_CLOSED;
        fin_kind  = KIND_CLOSED;
        ok        = 1'b0;
        cont      = 1'b0;
        cp        = '0;

        if (fire && item.first_byte)
        begin
            ns        = '0;
            ns.active = 1'b1;
            ns.qsel   = item.quote_kind;
        end
        q = ns.qsel ? BYTE_SQUOTE : BYTE_DQUOTE;

        if (fire && ns.active)
        begin
            if (ns.qpend)
            begin
                handled = 1'b1;
                if (b == q)
                begin
                    res[0]   = char_item({8'h00, q});
                    n        = CNT_W'(1);
                    ns.qpend = 1'b0;
                end
                else
                begin
                    do_finish = 1'b1;
                    base_kind = KIND_CLOSED;
                end
            end

            if (!handled && ns.remaining != UTF8_NONE)
            begin
                ok = (b >= UTF8_CONT_LO) && (b <= UTF8_CONT_HI);
                if (ns.remaining == UTF8_TWO && ns.lead == UTF8_LEAD3 && b < UTF8_E0_MIN)
                begin
                    ok = 1'b0;
                end
                if (ok)
                begin
                    handled = 1'b1;
                    if (ns.remaining == UTF8_TWO)
                    begin
                        ns.partial   = b;
                        ns.remaining = UTF8_LAST;
                    end
                    else
                    begin
                        if (ns.lead < UTF8_LEAD3)
                        begin
                            cp = {5'b0, ns.lead[4:0], b[5:0]};
                        end
                        else
                        begin
                            cp = {ns.lead[3:0], ns.partial[5:0], b[5:0]};
                        end
                        res[0]       = char_item(cp);
                        n            = CNT_W'(1);
                        ns.remaining = UTF8_NONE;
                    end
                end
                else
                begin
                    if (ns.err == ERR_NONE)
                    begin
                        ns.err = ERR_BAD_UTF8;
                    end
                    ns.remaining = UTF8_NONE;
                end
            end

            if (!handled && ns.esc_stage != ESC_NONE)
            begin
                cont = (ns.esc_stage == ESC_SLASH) ? (b == BYTE_LOWER_U) : is_hex(b);
                if (cont)
                begin
                    handled = 1'b1;
                    if (ns.esc_stage >= ESC_FULL)
                    begin
                        cp = {hex_val(ns.esc_bytes[2]), hex_val(ns.esc_bytes[3]),
                              hex_val(ns.esc_bytes[4]), hex_val(b)};
                        if (cp > 16'h00FF)
                        begin
                            ns.wide = 1'b1;
                        end
                        res[0]       = char_item(cp);
                        n            = CNT_W'(1);
                        ns.esc_stage = ESC_NONE;
                    end
                    else
                    begin
                        ns.esc_bytes[ns.esc_stage] = b;
                        ns.esc_stage               = ns.esc_stage + 3'd1;
                    end
                end
                else
                begin
                    // flush the broken escape as plain characters
                    for (int i = 0; i < ESC_DEPTH; i++)
                    begin
                        if (3'(i) < ns.esc_stage)
                        begin
                            res[i] = char_item({8'h00, ns.esc_bytes[i]});
                        end
                    end
                    n            = CNT_W'(ns.esc_stage);
                    ns.esc_stage = ESC_NONE;
                end
            end

            if (!handled)
            begin
                if (b == BYTE_LF || b == BYTE_CR)
                begin
                    do_finish = 1'b1;
                    base_kind = KIND_UNTERM;
                end
                else if (b == q)
                begin
                    ns.qpend = 1'b1;
                end
                else if (b == BYTE_BACKSLASH)
                begin
                    ns.esc_bytes[0] = b;
                    ns.esc_stage    = ESC_SLASH;
                end
                else if (b >= UTF8_CONT_LO)
                begin
                    if (mode_reg == MODE_ASCII)
                    begin
                        if (ns.err == ERR_NONE)
                        begin
                            ns.err = ERR_NON_ASCII;
                        end
                    end
                    else if (mode_reg == MODE_UTF8)
                    begin
                        ns.wide = 1'b1;
                        if (b < UTF8_MIN_LEAD)
                        begin
                            if (ns.err == ERR_NONE)
                            begin
                                ns.err = ERR_BAD_UTF8;
                            end
                        end
                        else
                        begin
                            ns.lead      = b;
                            ns.partial   = 8'h00;
                            ns.remaining = (b < UTF8_LEAD3) ? UTF8_LAST : UTF8_TWO;
                        end
                    end
                    else
                    begin
                        // latin1, and the unused mode code acts the same
                        res[n[IDX_W-1:0]] = char_item({8'h00, b});
                        n                 = n + CNT_W'(1);
                    end
                end
                else
                begin
                    res[n[IDX_W-1:0]] = char_item({8'h00, b});
                    n                 = n + CNT_W'(1);
                end
            end

            if (do_finish)
            begin
                fin_kind = base_kind;
                if (ns.err == ERR_NON_ASCII)
                begin
                    fin_kind = KIND_NON_ASCII;
                end
                else if (ns.err != ERR_NONE)
                begin
                    fin_kind = KIND_BAD_UTF8;
                end
                res[n[IDX_W-1:0]].code_point = 16'h0000;
                res[n[IDX_W-1:0]].item_kind  = fin_kind;
                res[n[IDX_W-1:0]].wide_flag  = ns.wide;
                n            = n + CNT_W'(1);
                ns.active    = 1'b0;
                ns.qpend     = 1'b0;
                ns.esc_stage = ESC_NONE;
                ns.remaining = UTF8_NONE;
            end
        end

        state_next = fire ? ns : state_reg;
        run        = res;
        run_count  = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            mode_reg  <= MODE_UTF8;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

endmodule

@@ hw/rtl/sld_run_buf.sv @@
module sld_run_buf
    import sld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  result_run_t      run,
    input  logic [CNT_W-1:0] run_count,
    output logic             run_free,
    output logic             out_valid,
    input  logic             out_stall,
    output result_t          result,
    output logic             last
);

    result_t          res_reg [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             take;

    assign out_valid = CNT_W'(idx_reg) < cnt_reg;
    assign last      = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign take      = out_valid && !out_stall;
    assign run_free  = !out_valid || (take && last);
    assign result    = res_reg[idx_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = run_count;
            idx_next = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_reg[i] <= run[i];
            end
        end
    end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sld_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 100;
    localparam int PHASE_ITEMS  = 24;
    localparam int N_PHASES     = 7;
    localparam int HOLD_PHASE   = 3;
    localparam int PAUSE_PHASE  = 5;
    localparam int DIR_ROWS     = 25;

    // encoding mode 3 decodes like latin1
    localparam logic [1:0] MODE_LATIN1_ALT = 2'd3;

    localparam logic [1:0] MODE_PLAN [N_PHASES] = '{
        MODE_ASCII, MODE_LATIN1, MODE_LATIN1_ALT, MODE_UTF8,
        MODE_ASCII, MODE_UTF8, MODE_LATIN1
    };

    typedef struct {
        logic [15:0] cp;
        item_kind_t  kind;
        logic        wide;
        logic        last;
    } decoded_t;

    typedef struct {
        logic [7:0]  b;
        logic        fst;
        logic        qk;
        logic        typed;
        logic        has_res;
        logic [15:0] cp;
        item_kind_t  kind;
        logic        wide;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        quote_kind;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] code_point;
    logic [2:0]  item_kind;
    logic        wide_flag;
    logic        last_of_run;

    string_literal_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .quote_kind  (quote_kind),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .item_kind   (item_kind),
        .wide_flag   (wide_flag),
        .last_of_run (last_of_run)
    );

    // decoder shadow state
    logic [1:0]  enc_mode;
    logic        lit_active;
    logic        lit_qsel;
    logic        lit_qpend;
    logic [2:0]  esc_cnt;
    logic [7:0]  esc_buf [ESC_DEPTH];
    logic [7:0]  u8_lead;
    logic [7:0]  u8_mid;
    logic [1:0]  u8_left;
    logic [1:0]  lit_err;
    logic        lit_wide;

    decoded_t    byte_results [$];
    decoded_t    awaited_items [$];
    in_item_t    lit_bytes [$];
    logic        lit_qk;

    int          mismatch_count;
    int          decoded_items;
    bit          burst_mode;
    bit          hold_off_req;
    dir_row_t    dir_tab [DIR_ROWS];

    always #2 clk = ~clk;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

    function automatic void emit(input logic [15:0] cp, input item_kind_t kind,
                                 input logic wide);
        decoded_t r;
        r.cp   = cp;
        r.kind = kind;
        r.wide = wide;
        r.last = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void clear_literal();
        lit_active = 1'b0;
        lit_qsel   = 1'b0;
        lit_qpend  = 1'b0;
        esc_cnt    = ESC_NONE;
        foreach (esc_buf[i])
            esc_buf[i] = 8'h00;
        u8_lead    = 8'h00;
        u8_mid     = 8'h00;
        u8_left    = UTF8_NONE;
        lit_err    = ERR_NONE;
        lit_wide   = 1'b0;
    endfunction

    function automatic void set_err(input logic [1:0] code);
        if (lit_err == ERR_NONE)
            lit_err = code;
    endfunction

    function automatic void close_literal(input item_kind_t base);
        item_kind_t kind;
        kind = base;
        if (lit_err == ERR_NON_ASCII)
            kind = KIND_NON_ASCII;
        else if (lit_err != ERR_NONE)
            kind = KIND_BAD_UTF8;
        emit(16'h0000, kind, lit_wide);
        lit_active = 1'b0;
        lit_qpend  = 1'b0;
        esc_cnt    = ESC_NONE;
        u8_left    = UTF8_NONE;
    endfunction

    // Decode one source byte into byte_results and advance the shadow state.
    function automatic void decode_byte(input logic [7:0] b, input logic fst,
                                        input logic qk);
        logic [7:0]  q;
        logic        ok;
        logic        done;
        logic [4:0]  hx;
        logic [4:0]  n2;
        logic [4:0]  n3;
        logic [4:0]  n4;
        logic [15:0] cp;
        decoded_t    r;
        byte_results.delete();
        if (fst)
        begin
            clear_literal();
            lit_active = 1'b1;
            lit_qsel   = qk;
        end
        else if (!lit_active)
        begin
            return;
        end
        q    = lit_qsel ? BYTE_SQUOTE : BYTE_DQUOTE;
        done = 1'b0;

        if (lit_qpend)
        begin
            if (b == q)
            begin
                emit({8'h00, q}, KIND_CHAR, 1'b0);
                lit_qpend = 1'b0;
            end
            else
            begin
                close_literal(KIND_CLOSED);
            end
            done = 1'b1;
        end

        if (!done && u8_left != UTF8_NONE)
        begin
            ok = (b >= UTF8_CONT_LO && b <= UTF8_CONT_HI);
            if (u8_left == UTF8_TWO && u8_lead == UTF8_LEAD3 && b < UTF8_E0_MIN)
                ok = 1'b0;
            if (ok)
            begin
                if (u8_left == UTF8_TWO)
                begin
                    u8_mid  = b;
                    u8_left = UTF8_LAST;
                end
                else
                begin
                    if (u8_lead < UTF8_LEAD3)
                        cp = {5'b0, u8_lead[4:0], b[5:0]};
                    else
                        cp = {u8_lead[3:0], u8_mid[5:0], b[5:0]};
                    emit(cp, KIND_CHAR, 1'b0);
                    u8_left = UTF8_NONE;
                end
                done = 1'b1;
            end
            else
            begin
                // drop the sequence, then take this byte afresh
                set_err(ERR_BAD_UTF8);
                u8_left = UTF8_NONE;
            end
        end

        if (!done && esc_cnt != ESC_NONE)
        begin
            hx = hex_nibble(b);
            ok = (esc_cnt == ESC_SLASH) ? (b == BYTE_LOWER_U) : hx[4];
            if (ok)
            begin
                if (esc_cnt >= ESC_FULL)
                begin
                    n2 = hex_nibble(esc_buf[2]);
                    n3 = hex_nibble(esc_buf[3]);
                    n4 = hex_nibble(esc_buf[4]);
                    cp = {n2[3:0], n3[3:0], n4[3:0], hx[3:0]};
                    if (cp > 16'h00FF)
                        lit_wide = 1'b1;
                    emit(cp, KIND_CHAR, 1'b0);
                    esc_cnt = ESC_NONE;
                end
                else
                begin
                    esc_buf[esc_cnt] = b;
                    esc_cnt = esc_cnt + 3'd1;
                end
                done = 1'b1;
            end
            else
            begin
                // flush the broken escape as plain characters
                for (int i = 0; i < int'(esc_cnt); i++)
                    emit({8'h00, esc_buf[i]}, KIND_CHAR, 1'b0);
                esc_cnt = ESC_NONE;
            end
        end

        if (!done)
        begin
            if (b == BYTE_LF || b == BYTE_CR)
            begin
                close_literal(KIND_UNTERM);
            end
            else if (b == q)
            begin
                lit_qpend = 1'b1;
            end
            else if (b == BYTE_BACKSLASH)
            begin
                esc_buf[0] = b;
                esc_cnt    = ESC_SLASH;
            end
            else if (b[7])
            begin
                if (enc_mode == MODE_ASCII)
                begin
                    set_err(ERR_NON_ASCII);
                end
                else if (enc_mode == MODE_UTF8)
                begin
                    lit_wide = 1'b1;
                    if (b < UTF8_MIN_LEAD)
                    begin
                        set_err(ERR_BAD_UTF8);
                    end
                    else
                    begin
                        u8_lead = b;
                        u8_mid  = 8'h00;
                        u8_left = (b < UTF8_LEAD3) ? UTF8_LAST : UTF8_TWO;
                    end
                end
                else
                begin
                    emit({8'h00, b}, KIND_CHAR, 1'b0);
                end
            end
            else
            begin
                emit({8'h00, b}, KIND_CHAR, 1'b0);
            end
        end

        if (byte_results.size() > 0)
        begin
            r = byte_results.pop_back();
            r.last = 1'b1;
            byte_results.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_out
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_items.size() == 0)
            begin
                report_mismatch("result with nothing pending", code_point, 16'h0);
            end
            else
            begin
                want = awaited_items.pop_front();
                if (code_point !== want.cp)
                    report_mismatch("code_point", code_point, want.cp);
                if (item_kind !== want.kind)
                    report_mismatch("item_kind", 16'(item_kind), 16'(want.kind));
                if (wide_flag !== want.wide)
                    report_mismatch("wide_flag", 16'(wide_flag), 16'(want.wide));
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", 16'(last_of_run), 16'(want.last));
            end
        end
    end

    // Receiver: random stall runs, plus one long hold-off on request.
    initial
    begin : receiver
        int run_left;
        int hold_left;
        int r;
        run_left  = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                run_left  = 0;
                out_stall <= 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r <= 5)
                begin
                    out_stall <= 1'b0;
                    run_left  = $urandom_range(1, 4);
                end
                else if (r <= 7)
                begin
                    out_stall <= 1'b0;
                    run_left  = $urandom_range(20, 60);
                end
                else if (r == 8)
                begin
                    out_stall <= 1'b1;
                    run_left  = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run_left  = $urandom_range(10, 30);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 17)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic fst, input logic qk,
                             input bit use_predictor);
        int gap;
        bit ignored;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= fst;
        quote_kind <= qk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ignored = !fst && !lit_active;
        decode_byte(b, fst, qk);
        if (!ignored)
            decoded_items++;
        if (use_predictor)
            foreach (byte_results[i])
                awaited_items.push_back(byte_results[i]);
    endtask

    // Drop valid, then hold until every pending result is out and the pipe is quiet.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (awaited_items.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        enc_mode = m;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        in_item_t it;
        it.data_byte  = b;
        it.first_byte = (lit_bytes.size() == 0);
        it.quote_kind = lit_qk;
        lit_bytes.push_back(it);
    endfunction

    function automatic logic [7:0] plain_char(input logic [7:0] q);
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == q || c == BYTE_BACKSLASH);
        return c;
    endfunction

    function automatic logic [7:0] hex_digit();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'(8'h30 + r);
        if (r < 16)
            return 8'(8'h61 + r - 10);
        return 8'(8'h41 + r - 16);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(UTF8_CONT_LO, UTF8_CONT_HI));
    endfunction

    // Build one literal from random tokens and, unless it is left open, a random terminator, then send it.
    task automatic send_literal();
        logic [7:0] q;
        logic [7:0] c;
        int         ntok;
        int         r;
        lit_bytes.delete();
        lit_qk = 1'($urandom_range(0, 1));
        q      = lit_qk ? BYTE_SQUOTE : BYTE_DQUOTE;
        ntok   = $urandom_range(0, 6);
        repeat (ntok)
        begin
            r = $urandom_range(0, 11);
            case (r)
                0, 1, 2:
                    add_byte(plain_char(q));
                3:
                begin
                    add_byte(q);
                    add_byte(q);
                end
                4, 5:
                begin
                    add_byte(BYTE_BACKSLASH);
                    add_byte(BYTE_LOWER_U);
                    repeat (4) add_byte(hex_digit());
                end
                6:
                begin
                    add_byte(BYTE_BACKSLASH);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        add_byte(BYTE_LOWER_U);
                        repeat ($urandom_range(0, 3)) add_byte(hex_digit());
                    end
                end
                7, 8:
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        add_byte(8'($urandom_range(UTF8_MIN_LEAD, 8'hDF)));
                        add_byte(cont_byte());
                    end
                    else
                    begin
                        c = 8'($urandom_range(UTF8_LEAD3, 8'hFF));
                        add_byte(c);
                        if (c == UTF8_LEAD3)
                            add_byte(8'($urandom_range(UTF8_E0_MIN, UTF8_CONT_HI)));
                        else
                            add_byte(cont_byte());
                        add_byte(cont_byte());
                    end
                end
                9:
                begin
                    case ($urandom_range(0, 2))
                        0:
                            add_byte(8'($urandom_range(UTF8_CONT_LO, 8'hC1)));
                        1:
                        begin
                            add_byte(8'($urandom_range(UTF8_MIN_LEAD, 8'hFF)));
                            add_byte(plain_char(q));
                        end
                        default:
                        begin
                            add_byte(UTF8_LEAD3);
                            add_byte(8'($urandom_range(UTF8_CONT_LO, 8'h9F)));
                        end
                    endcase
                end
                10:
                    add_byte(8'($urandom_range(8'h80, 8'hFF)));
                default:
                    add_byte(8'($urandom_range(0, 255)));
            endcase
        end
        r = $urandom_range(0, 9);
        if (r <= 6)
        begin
            add_byte(q);
            do
                c = 8'($urandom_range(0, 255));
            while (c == q);
            add_byte(c);
        end
        else if (r <= 8)
        begin
            add_byte((r == 7) ? BYTE_CR : BYTE_LF);
        end
        else if (lit_bytes.size() == 0)
        begin
            // abandon the literal: the next one restarts it
            add_byte(plain_char(q));
        end
        foreach (lit_bytes[i])
            send_item(lit_bytes[i].data_byte, lit_bytes[i].first_byte,
                      lit_bytes[i].quote_kind, 1'b1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0),
                      1'($urandom_range(0, 1)), 1'b1);
    endtask

    initial
    begin : stimulus
        decoded_t want;
        int       phase_start;
        bit       paused;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = MODE_ASCII;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        first_byte   = 1'b0;
        quote_kind   = 1'b0;
        mismatch_count = 0;
        decoded_items  = 0;
        burst_mode     = 1'b0;
        hold_off_req   = 1'b0;
        enc_mode       = MODE_UTF8;
        clear_literal();

        // data, first, quote kind, typed, has result, code point, kind, wide
        dir_tab = '{
            '{8'h41, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h22, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h22, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0022, KIND_CHAR,     1'b0},
            '{8'h5C, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h75, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h46, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h66, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h30, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h39, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'hE0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'hA0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'hC2, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'hC1, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h27, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h20, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000, KIND_BAD_UTF8, 1'b1},
            '{8'h5C, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h75, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h61, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h42, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h33, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0},
            '{8'h0A, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_CHAR,     1'b0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            send_item(dir_tab[k].b, dir_tab[k].fst, dir_tab[k].qk, !dir_tab[k].typed);
            if (dir_tab[k].typed && dir_tab[k].has_res)
            begin
                want.cp   = dir_tab[k].cp;
                want.kind = dir_tab[k].kind;
                want.wide = dir_tab[k].wide;
                want.last = 1'b1;
                awaited_items.push_back(want);
            end
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_mode(MODE_PLAN[p]);
            phase_start = decoded_items;
            paused      = 1'b0;
            if (p == HOLD_PHASE)
            begin
                // back-to-back bytes against a stalled consumer
                hold_off_req = 1'b1;
                burst_mode   = 1'b1;
            end
            while (decoded_items - phase_start < PHASE_ITEMS)
            begin
                if (p == PAUSE_PHASE && !paused &&
                    decoded_items - phase_start >= PHASE_ITEMS / 2)
                begin
                    wait_drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                else
                    send_literal();
            end
            burst_mode = 1'b0;
        end

        wait_drain();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
